FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, off while reset is low.
`define ELNN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check sampled on the rising clock, live during reset too.
`define ELNN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/elnn_pkg.sv
// Types and codes shared by the edge list nearest neighbour query block.
package elnn_pkg;

    // Request kinds carried on the slave tuser.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [7:0]  start_node;
        logic [7:0]  end_node;
        logic [15:0] weight;
    } t_edge;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIN,
        ST_EMIT,
        ST_NONE
    } t_state;

endpackage

FILE: rtl/core/elnn_cell.sv
// One storage cell of the edge ring: holds an edge, loads or takes its neighbor's.
module elnn_cell (
    input  logic                i_clk,
    input  elnn_pkg::t_cell_ctrl i_ctrl,
    input  elnn_pkg::t_edge     i_prev,
    input  elnn_pkg::t_edge     i_load_edge,
    output elnn_pkg::t_edge     o_edge
);

    elnn_pkg::t_edge r_edge;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_edge <= i_load_edge;
        end else if (i_ctrl.shift) begin
            r_edge <= i_prev;
        end
    end

    assign o_edge = r_edge;

endmodule

FILE: rtl/core/edge_list_nearest_neighbour_query.sv
// Top level of the edge list nearest neighbour query block.
//
// Edges are held in a ring of MAX_EDGES cells; cell 0 is the head and every
// cell hands its edge to the cell below it when the ring turns. A load request
// writes the cell at the current edge count (dropped when the table is full), a
// clear request zeroes the count; neither gives a result. A query request turns
// the ring: the first full turn finds the smallest weight among edges touching
// the node (first end only if directed) and counts how many results it will
// give, the second turn emits the far end of each such edge in load order, with
// tlast on the final one. The second turn holds the ring while the master
// stalls and while an undirected self-loop sends its second end. A query with
// no hit returns one result with found low. Every full turn puts each edge back
// in place. The result register lets the master hold the last result while the
// next request is taken. The directed register is to be written through
// i_cfg_we only while idle; the block itself does not enforce this.
module edge_list_nearest_neighbour_query #(
    parameter int MAX_EDGES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,     // directed
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,    // first_end, second_end, edge_weight, query_node
    input  logic [1:0]  s_axis_tuser,    // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // neighbour_node
    output logic        m_axis_tuser,    // found
    output logic        m_axis_tlast     // last
);

    localparam int CNT_W = $clog2(MAX_EDGES + 1);
    localparam int RES_W = $clog2(2 * MAX_EDGES + 1);

    // Request fields
    logic [1:0]  in_cmd;
    logic [7:0]  in_first;
    logic [7:0]  in_second;
    logic [15:0] in_weight;
    logic [7:0]  in_query;
    assign in_cmd    = s_axis_tuser;
    assign in_first  = s_axis_tdata[7:0];
    assign in_second = s_axis_tdata[15:8];
    assign in_weight = s_axis_tdata[31:16];
    assign in_query  = s_axis_tdata[39:32];

    elnn_pkg::t_state r_state, n_state;
    logic             r_directed;
    logic [CNT_W-1:0] r_total, n_total;
    logic [CNT_W-1:0] r_pos, n_pos;       // table index now at the head cell
    logic [7:0]       r_query, n_query;
    logic [15:0]      r_best, n_best;
    logic             r_any, n_any;
    logic [RES_W-1:0] r_count, n_count;   // results this query will give
    logic [RES_W-1:0] r_sent, n_sent;     // results given so far
    logic             r_half, n_half;     // start end of a self-loop already sent

    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_node, n_out_node;
    logic             r_out_found, n_out_found;
    logic             r_out_last, n_out_last;

    logic             shift;
    logic             load;
    elnn_pkg::t_edge  load_edge;
    elnn_pkg::t_edge  cell_q [MAX_EDGES];

    // Ring of cells
    assign load_edge = '{start_node: in_first, end_node: in_second, weight: in_weight};

    for (genvar g = 0; g < MAX_EDGES; g++) begin : g_cell
        elnn_pkg::t_cell_ctrl ctrl;
        assign ctrl.shift = shift;
        assign ctrl.load  = load && (r_total == CNT_W'(g));
        elnn_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_prev      (cell_q[(g + 1) % MAX_EDGES]),
            .i_load_edge (load_edge),
            .o_edge      (cell_q[g])
        );
    end

    // Head cell compare
    elnn_pkg::t_edge head;
    logic            head_valid;
    logic            hit_start;
    logic            hit_end;
    logic [1:0]      hit_mult;
    logic            at_end;
    logic            out_free;
    logic            emit_need;
    logic            is_last;

    assign head       = cell_q[0];
    assign head_valid = r_pos < r_total;
    assign hit_start  = head_valid && (head.start_node == r_query);
    assign hit_end    = head_valid && !r_directed && (head.end_node == r_query);
    assign hit_mult   = {1'b0, hit_start} + {1'b0, hit_end};
    assign at_end     = r_pos == CNT_W'(MAX_EDGES - 1);
    assign out_free   = !r_out_valid || m_axis_tready;
    assign emit_need  = (head.weight == r_best) && ((hit_start && !r_half) || hit_end);
    assign is_last    = (r_sent + RES_W'(1)) == r_count;

    assign s_axis_tready = r_state == elnn_pkg::ST_IDLE;

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_pos       = r_pos;
        n_query     = r_query;
        n_best      = r_best;
        n_any       = r_any;
        n_count     = r_count;
        n_sent      = r_sent;
        n_half      = r_half;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_node  = r_out_node;
        n_out_found = r_out_found;
        n_out_last  = r_out_last;
        shift       = 1'b0;
        load        = 1'b0;

        case (r_state)
            elnn_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    case (in_cmd)
                        elnn_pkg::CMD_LOAD: begin
                            // drop the edge once the table is full
                            if (r_total < CNT_W'(MAX_EDGES)) begin
                                load    = 1'b1;
                                n_total = r_total + CNT_W'(1);
                            end
                        end
                        elnn_pkg::CMD_QUERY: begin
                            n_query = in_query;
                            n_pos   = '0;
                            n_any   = 1'b0;
                            n_count = '0;
                            n_state = elnn_pkg::ST_MIN;
                        end
                        elnn_pkg::CMD_CLEAR: begin
                            n_total = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            elnn_pkg::ST_MIN: begin
                shift = 1'b1;
                n_pos = r_pos + CNT_W'(1);
                if (hit_mult != 2'd0) begin
                    if (!r_any || (head.weight < r_best)) begin
                        n_best  = head.weight;
                        n_count = RES_W'(hit_mult);
                        n_any   = 1'b1;
                    end else if (head.weight == r_best) begin
                        n_count = r_count + RES_W'(hit_mult);
                    end
                end
                if (at_end) begin
                    n_pos  = '0;
                    n_sent = '0;
                    n_half = 1'b0;
                    n_state = (r_any || (hit_mult != 2'd0)) ? elnn_pkg::ST_EMIT
                                                            : elnn_pkg::ST_NONE;
                end
            end

            elnn_pkg::ST_EMIT: begin
                if (!emit_need) begin
                    shift  = 1'b1;
                    n_half = 1'b0;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = 1'b1;
                    n_out_last  = is_last;
                    n_sent      = r_sent + RES_W'(1);
                    if (hit_start && !r_half) begin
                        n_out_node = head.end_node;
                        // a self-loop holds the ring to send its other end as the next result
                        if (hit_end) begin
                            n_half = 1'b1;
                        end else begin
                            shift = 1'b1;
                        end
                    end else begin
                        n_out_node = head.start_node;
                        n_half     = 1'b0;
                        shift      = 1'b1;
                    end
                end
                if (shift) begin
                    n_pos = r_pos + CNT_W'(1);
                    if (at_end) begin
                        n_pos   = '0;
                        n_state = elnn_pkg::ST_IDLE;
                    end
                end
            end

            elnn_pkg::ST_NONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_node  = '0;
                    n_out_found = 1'b0;
                    n_out_last  = 1'b1;
                    n_state     = elnn_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = elnn_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= elnn_pkg::ST_IDLE;
            r_directed  <= 1'b0;
            r_total     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_directed <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_query     <= n_query;
        r_best      <= n_best;
        r_any       <= n_any;
        r_count     <= n_count;
        r_sent      <= n_sent;
        r_half      <= n_half;
        r_out_node  <= n_out_node;
        r_out_found <= n_out_found;
        r_out_last  <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_node;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: rtl/core/elnn_chk.sv
// Port checker for the edge list nearest neighbour query block, with its bind.
`include "assert_macros.svh"

module elnn_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        i_cfg_wdata,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    `ELNN_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")
    `ELNN_ASSERT(a_miss_last, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast, "miss result without tlast")
    `ELNN_ASSERT(a_miss_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'd0, "miss result with nonzero node")
    `ELNN_ASSERT(a_reset_quiet, i_clk, i_rst_n, !$past(i_rst_n) |-> !m_axis_tvalid, "result right after reset")

endmodule

bind edge_list_nearest_neighbour_query elnn_chk u_elnn_chk (.*);

FILE: dv/tb_edge_list_nearest_neighbour_query.sv
// Self-checking testbench for the edge list nearest neighbour query block.
`timescale 1ns / 100ps

module tb_edge_list_nearest_neighbour_query;

    localparam int         MAX_EDGES     = 32;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    // Cycles to let a load or clear drain before a register write.
    localparam int         SETTLE_CYCLES = 2 * MAX_EDGES + 8;
    // Cycles with no request moving on either side before giving up.
    localparam int         STALL_LIMIT   = 4000;
    // Length of the long receiver hold-off.
    localparam int         HOLD_CYCLES   = 400;

    typedef struct {
        logic [7:0] node;
        logic       found;
        logic       last;
    } t_neighbour;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;     // first_end, second_end, edge_weight, query_node
    logic [1:0]  s_axis_tuser;     // command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;     // neighbour_node
    logic        m_axis_tuser;     // found
    logic        m_axis_tlast;     // last

    // Shadow of the edge table and the directed register.
    logic [7:0]  shadow_start [MAX_EDGES];
    logic [7:0]  shadow_end   [MAX_EDGES];
    logic [15:0] shadow_weight[MAX_EDGES];
    int          shadow_count;
    bit          directed_mode;

    t_neighbour  pending_neighbours[$];
    t_neighbour  oldest_neighbour;
    int          error_count = 0;
    int          idle_cycles = 0;
    int          stall_left;
    int          hold_requests = 0;
    bit          steady;

    edge_list_nearest_neighbour_query #(
        .MAX_EDGES(MAX_EDGES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Nearest neighbour predictor
    // ------------------------------------------------------------------
    function automatic void push_neighbour(input logic [7:0] node, input logic found,
                                           input logic last);
        t_neighbour item;
        item.node  = node;
        item.found = found;
        item.last  = last;
        pending_neighbours.push_back(item);
    endfunction

    function automatic void predict_request(input logic [1:0] cmd, input logic [7:0] a,
                                            input logic [7:0] b, input logic [15:0] w,
                                            input logic [7:0] q);
        bit          any;
        logic [15:0] best;
        int          total;
        int          k;
        bit          hit;
        any   = 0;
        best  = '0;
        total = 0;
        k     = 0;
        case (cmd)
            elnn_pkg::CMD_LOAD: begin
                // Drop the edge once the table is full.
                if (shadow_count < MAX_EDGES) begin
                    shadow_start[shadow_count]  = a;
                    shadow_end[shadow_count]    = b;
                    shadow_weight[shadow_count] = w;
                    shadow_count++;
                end
            end
            elnn_pkg::CMD_CLEAR: begin
                shadow_count = 0;
            end
            elnn_pkg::CMD_QUERY: begin
                // Find the shortest incident weight.
                for (int i = 0; i < shadow_count; i++) begin
                    hit = (shadow_start[i] == q) || (!directed_mode && shadow_end[i] == q);
                    if (hit && (!any || shadow_weight[i] < best)) begin
                        best = shadow_weight[i];
                        any  = 1;
                    end
                end
                if (!any) begin
                    push_neighbour(8'd0, 1'b0, 1'b1);
                end else begin
                    // Count the hits first so tlast lands on the final one.
                    for (int i = 0; i < shadow_count; i++) begin
                        if (shadow_weight[i] == best) begin
                            if (shadow_start[i] == q) total++;
                            if (!directed_mode && shadow_end[i] == q) total++;
                        end
                    end
                    // Emit far ends in load order; a self-loop emits twice when undirected.
                    for (int i = 0; i < shadow_count; i++) begin
                        if (shadow_weight[i] == best) begin
                            if (shadow_start[i] == q) begin
                                push_neighbour(shadow_end[i], 1'b1, k == total - 1);
                                k++;
                            end
                            if (!directed_mode && shadow_end[i] == q) begin
                                push_neighbour(shadow_start[i], 1'b1, k == total - 1);
                                k++;
                            end
                        end
                    end
                end
            end
            default: ;  // unused code: ignored
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    // Offer one request at the falling edge, hold it until accepted, then predict.
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] a,
                                input logic [7:0] b, input logic [15:0] w,
                                input logic [7:0] q);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 18) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {q, w, b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_request(cmd, a, b, w, q);
    endtask

    // Ignored fields carry random values.
    task automatic send_load(input logic [7:0] a, input logic [7:0] b, input logic [15:0] w);
        send_request(elnn_pkg::CMD_LOAD, a, b, w, 8'($urandom));
    endtask

    task automatic send_query(input logic [7:0] q);
        send_request(elnn_pkg::CMD_QUERY, 8'($urandom), 8'($urandom), 16'($urandom), q);
    endtask

    task automatic send_other(input logic [1:0] cmd);
        send_request(cmd, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // Drain everything, let the block go idle, then write the directed register.
    task automatic set_directed(input bit value);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_neighbours.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we      = 1'b0;
        directed_mode = value;
    endtask

    // ------------------------------------------------------------------
    // Result sink: random tready with an optional long hold-off
    // ------------------------------------------------------------------
    initial begin
        int hold_seen;
        hold_seen     = 0;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != hold_seen) begin
                hold_seen  = hold_requests;
                stall_left = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                m_axis_tready = 1'b0;
            end else if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                m_axis_tready = steady || ($urandom_range(0, 99) >= 18);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int expected, input int got);
        $display("%0t ns: %s expected %0d got %0d", $time, what, expected, got);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_neighbours.size() == 0) begin
                report_mismatch("unexpected result, neighbour_node", -1, m_axis_tdata);
            end else begin
                oldest_neighbour = pending_neighbours.pop_front();
                if (m_axis_tdata !== oldest_neighbour.node)
                    report_mismatch("neighbour_node", oldest_neighbour.node, m_axis_tdata);
                if (m_axis_tuser !== oldest_neighbour.found)
                    report_mismatch("found", oldest_neighbour.found, m_axis_tuser);
                if (m_axis_tlast !== oldest_neighbour.last)
                    report_mismatch("last", oldest_neighbour.last, m_axis_tlast);
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("edge_list_nearest_neighbour_query: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Query an empty table at both node extremes; unused code and clear give nothing.
    task automatic test_empty_table();
        send_query(8'd0);
        send_other(CMD_UNUSED);
        send_other(elnn_pkg::CMD_CLEAR);
        send_query(8'd255);
    endtask

    // Node and weight extremes, a self-loop and a tie, undirected.
    task automatic test_undirected_queries();
        send_load(8'd0,   8'd255, 16'd0);
        send_load(8'd255, 8'd0,   16'd65535);
        send_load(8'd3,   8'd3,   16'd9);
        send_load(8'd3,   8'd5,   16'd9);
        send_load(8'd5,   8'd3,   16'd9);
        send_load(8'd3,   8'd7,   16'd10);
        send_query(8'd3);     // self-loop twice plus the tie
        send_query(8'd0);
        send_query(8'd255);
        send_query(8'd7);
        send_query(8'd4);     // no hit
    endtask

    // Same table, first end only.
    task automatic test_directed_queries();
        send_query(8'd3);
        send_query(8'd5);
        send_query(8'd255);
        send_query(8'd7);     // only a second end matches: no hit
        send_other(elnn_pkg::CMD_CLEAR);
        send_query(8'd3);
    endtask

    // Fill with self-loops past capacity: the extra edge drops, the query gives 64 results.
    task automatic test_table_overflow();
        send_other(elnn_pkg::CMD_CLEAR);
        for (int i = 0; i < MAX_EDGES; i++)
            send_load(8'd7, 8'd7, 16'd5);
        send_load(8'd7, 8'd9, 16'd0);
        send_query(8'd7);
        send_query(8'd9);
    endtask

    // Hold tready low for a long stretch while queries keep coming.
    task automatic test_output_backpressure();
        hold_requests++;
        for (int i = 0; i < 6; i++)
            send_query(8'd7);
    endtask

    function automatic logic [7:0] pick_node();
        // Mostly a few nodes so queries hit; sometimes any node.
        if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_weight();
        // Small weights make ties common.
        if ($urandom_range(0, 99) < 80) return 16'($urandom_range(0, 3));
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic test_random_traffic(input int count);
        int roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 56)
                send_load(pick_node(), pick_node(), pick_weight());
            else if (roll < 94)
                send_query(pick_node());
            else if (roll < 96)
                send_other(elnn_pkg::CMD_CLEAR);
            else
                send_other(CMD_UNUSED);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = elnn_pkg::CMD_LOAD;
        shadow_count  = 0;
        directed_mode = 0;
        steady        = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        set_directed(1'b0);
        test_empty_table();
        test_undirected_queries();
        set_directed(1'b1);
        test_directed_queries();
        set_directed(1'b0);
        test_table_overflow();
        test_output_backpressure();

        steady = 1;
        test_random_traffic(95);
        steady = 0;
        set_directed(1'b1);
        test_random_traffic(125);
        set_directed(1'b0);
        test_random_traffic(75);
        set_directed(1'b1);
        test_random_traffic(62);

        // Drop valid, drain, and give the block time to show any stray result.
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_neighbours.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("edge_list_nearest_neighbour_query: match");
        end else begin
            $display("edge_list_nearest_neighbour_query: mismatch");
        end
        $finish;
    end

endmodule
